[rtl/core/face_edge_dedup_table_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the face edge dedup table
// Immediate-consequence and next-cycle implication checks, clocked and
// disabled during reset. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FACE_EDGE_DEDUP_TABLE_MACROS_SVH
`define FACE_EDGE_DEDUP_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define FEDT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FEDT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FEDT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define FEDT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/fedt_pkg.sv]
// ----------------------------------------------------------------------------
// Face edge dedup table package
// Field widths, status codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fedt_pkg;

   localparam int NODE_W     = 20;
   localparam int EDGE_NUM_W = 12;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_START,
      S_PROBE,
      S_CMP,
      S_EMIT
   } state_type;

   // What the pending result is made of.
   typedef enum logic [1:0] {
      KIND_HIT,
      KIND_NEW,
      KIND_LONG,
      KIND_PAIR
   } kind_type;

   typedef struct packed {
      logic     capture;
      logic     clear;
      logic     start_edge;
      logic     rd;
      logic     scan_inc;
      logic     emit;
      logic     adv;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic overlong;
      logic is_short;
      logic is_pair;
      logic a_last;
      logic scan_done;
      logic match;
      logic out_free;
   } sts_type;

endpackage

[rtl/core/fedt_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fedt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/fedt_ctrl.sv]
// ----------------------------------------------------------------------------
// Face edge dedup controller
// Sequences buffering, the per-edge table scan and result emission.
// ----------------------------------------------------------------------------
module fedt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_last,
   output logic             in_ready,
   input  fedt_pkg::sts_type sts,
   output fedt_pkg::cmd_type cmd
);
   import fedt_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_NEW;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.capture = 1'b1;
               if (in_last) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (sts.overlong) begin
               kind_in  = KIND_LONG;
               state_in = S_EMIT;
            end else if (sts.is_short) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end else if (sts.is_pair) begin
               kind_in  = KIND_PAIR;
               state_in = S_START;
            end else begin
               kind_in  = KIND_NEW;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start_edge = 1'b1;
            state_in = (kind_ff == KIND_PAIR) ? S_EMIT : S_PROBE;
         end
         S_PROBE: begin
            if (sts.scan_done) begin
               kind_in  = KIND_NEW;
               state_in = S_EMIT;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               kind_in  = KIND_HIT;
               state_in = S_EMIT;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_PROBE;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (kind_ff == KIND_LONG || sts.a_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cmd.adv  = 1'b1;
                  state_in = S_START;
                  if (kind_ff != KIND_PAIR) begin
                     kind_in = KIND_NEW;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/fedt_dpath.sv]
// ----------------------------------------------------------------------------
// Face edge dedup datapath
// Corner buffer, edge ordering, edge table scan and the result register.
// ----------------------------------------------------------------------------
`include "face_edge_dedup_table_macros.svh"
module fedt_dpath #(
   parameter int MAX_EDGES      = 4096,
   parameter int MAX_FACE_NODES = 8,
   parameter int NODE_BITS      = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [fedt_pkg::NODE_W-1:0]        node_i,
   input  fedt_pkg::cmd_type                  cmd,
   output fedt_pkg::sts_type                  sts,
   input  logic                               out_ready,
   output logic                               out_valid,
   output logic [fedt_pkg::EDGE_NUM_W-1:0]    out_num,
   output logic                               out_new,
   output logic [fedt_pkg::NODE_W-1:0]        out_lo,
   output logic [fedt_pkg::NODE_W-1:0]        out_hi,
   output logic [fedt_pkg::STATUS_W-1:0]      out_status,
   output logic                               out_last
);
   import fedt_pkg::*;

   localparam int FW = $clog2(MAX_FACE_NODES + 1);
   localparam int IW = $clog2(MAX_FACE_NODES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int AW = $clog2(MAX_EDGES);

   logic [NODE_BITS-1:0] face_ff [MAX_FACE_NODES];
   logic [FW-1:0]        fill_ff, fill_in;
   logic                 overlong_ff, overlong_in;
   logic [IW-1:0]        a_ff, a_in;
   logic [NODE_BITS-1:0] q_ff, lo_ff, hi_ff;
   logic [CW-1:0]        scan_ff, scan_in;
   logic [CW-1:0]        used_ff, used_in;

   logic                 valid_ff, valid_in;
   logic [EDGE_NUM_W-1:0] num_ff;
   logic                 new_ff, last_ff;
   logic [NODE_W-1:0]    olo_ff, ohi_ff;
   logic [STATUS_W-1:0]  st_ff;

   logic [NODE_BITS-1:0]   node_m, sel, p;
   logic [IW-1:0]          nxt, rd_idx;
   logic                   a_last, used_full, wr_en;
   logic [2*NODE_BITS-1:0] rd_data;

   assign node_m    = NODE_BITS'(node_i);
   assign a_last    = (FW'(a_ff) + FW'(1)) == fill_ff;
   assign nxt       = a_last ? '0 : a_ff + IW'(1);
   assign rd_idx    = (cmd.kind == KIND_PAIR) ? a_ff : nxt;
   assign sel       = face_ff[rd_idx];
   assign p         = (a_ff == '0) ? face_ff[0] : q_ff;
   assign used_full = used_ff == CW'(MAX_EDGES);
   assign wr_en     = cmd.emit && cmd.kind == KIND_NEW && !used_full;

   assign sts.overlong  = overlong_ff;
   assign sts.is_short  = fill_ff < FW'(2);
   assign sts.is_pair   = fill_ff == FW'(2);
   assign sts.a_last    = a_last;
   assign sts.scan_done = scan_ff == used_ff;
   assign sts.match     = rd_data == {hi_ff, lo_ff};
   assign sts.out_free  = !valid_ff || out_ready;

   fedt_ram #(
      .WIDTH (2 * NODE_BITS),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (used_ff[AW-1:0]),
      .wr_data ({hi_ff, lo_ff}),
      .rd_en   (cmd.rd),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      fill_in     = fill_ff;
      overlong_in = overlong_ff;
      a_in        = a_ff;
      scan_in     = scan_ff;
      used_in     = used_ff;
      valid_in    = valid_ff && !out_ready;
      if (cmd.capture) begin
         if (fill_ff < FW'(MAX_FACE_NODES)) begin
            fill_in = fill_ff + FW'(1);
         end else begin
            overlong_in = 1'b1;
         end
      end
      if (cmd.start_edge) begin
         scan_in = '0;
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + CW'(1);
      end
      if (cmd.adv) begin
         a_in = a_ff + IW'(1);
      end
      if (wr_en) begin
         used_in = used_ff + CW'(1);
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
      end
      if (cmd.clear) begin
         fill_in     = '0;
         overlong_in = 1'b0;
         a_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         overlong_ff <= 1'b0;
         a_ff        <= '0;
         scan_ff     <= '0;
         used_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         overlong_ff <= overlong_in;
         a_ff        <= a_in;
         scan_ff     <= scan_in;
         used_ff     <= used_in;
         valid_ff    <= valid_in;
      end
   end

   // Payload registers: corner buffer, current edge and the result.
   always_ff @(posedge clock) begin
      if (cmd.capture && fill_ff < FW'(MAX_FACE_NODES)) begin
         face_ff[fill_ff[IW-1:0]] <= node_m;
      end
      if (cmd.start_edge) begin
         q_ff <= sel;
         if (cmd.kind == KIND_PAIR) begin
            lo_ff <= sel;
            hi_ff <= sel;
         end else begin
            lo_ff <= (p < sel) ? p : sel;
            hi_ff <= (p < sel) ? sel : p;
         end
      end
      if (cmd.emit) begin
         last_ff <= (cmd.kind == KIND_LONG) ? 1'b1 : a_last;
         olo_ff  <= NODE_W'(lo_ff);
         ohi_ff  <= NODE_W'(hi_ff);
         new_ff  <= 1'b0;
         st_ff   <= ST_OK;
         case (cmd.kind)
            KIND_HIT: begin
               num_ff <= EDGE_NUM_W'(scan_ff);
            end
            KIND_NEW: begin
               if (used_full) begin
                  num_ff <= '0;
                  st_ff  <= ST_FULL;
               end else begin
                  num_ff <= EDGE_NUM_W'(used_ff);
                  new_ff <= 1'b1;
               end
            end
            KIND_PAIR: begin
               num_ff <= EDGE_NUM_W'(lo_ff);
            end
            default: begin
               num_ff <= '0;
               olo_ff <= '0;
               ohi_ff <= '0;
               st_ff  <= ST_LONG;
            end
         endcase
      end
   end

   assign out_valid  = valid_ff;
   assign out_num    = num_ff;
   assign out_new    = new_ff;
   assign out_lo     = olo_ff;
   assign out_hi     = ohi_ff;
   assign out_status = st_ff;
   assign out_last   = last_ff;

   `FEDT_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= CW'(MAX_EDGES), "edge count overflow")
   `FEDT_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, !valid_ff || out_ready, "result overwritten")
   `FEDT_ASSERT_IMP(a_scan_bound, clock, reset, cmd.rd, scan_ff < used_ff, "scan beyond table fill")

endmodule

[rtl/core/face_edge_dedup_table.sv]
// ----------------------------------------------------------------------------
// Face edge dedup table
// Buffers the corners of a mesh face and, when the face closes, emits each
// edge with its deduplicated edge number from an edge table.
// ----------------------------------------------------------------------------
//
//   Channel | Ports   | Content
//   --------+---------+------------------------------------------------------
//   input   | req_*   | one face corner per transfer, tlast closes the face
//   result  | rsp_*   | one edge per transfer, tlast on the face's last edge
//
// A corner that does not close a face is accepted while the controller is
// idle. After a closing corner the controller takes one decision step and
// then, per edge, starts the edge, scans the edge table linearly with a
// registered read of the edge RAM and a compare per entry, and emits the
// result; a two-node face skips the scan and an overlong face goes straight
// from the decision to its single result.
// Reset clears counters and valid state only; the edge RAM needs no clearing
// since only entries below the fill count are ever read.
// A stalled result holds the controller in its emit step; corners are
// accepted whenever the controller is idle, even while a result waits.
// ----------------------------------------------------------------------------
module face_edge_dedup_table #(
   parameter int MAX_EDGES      = 4096,
   parameter int MAX_FACE_NODES = 8,
   parameter int NODE_BITS      = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // node[19:0], zero fill
   input  logic        req_tlast,   // last_of_face
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // edge_number[11:0], is_new, low_node, high_node, zero fill
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast    // last_of_run
);
   import fedt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   logic [EDGE_NUM_W-1:0] num;
   logic                  is_new;
   logic [NODE_W-1:0]     lo, hi;

   // The controller owns the input handshake; the datapath owns the result
   // register and reports whether it can take a new result.
   fedt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   fedt_dpath #(
      .MAX_EDGES      (MAX_EDGES),
      .MAX_FACE_NODES (MAX_FACE_NODES),
      .NODE_BITS      (NODE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .node_i     (req_tdata[NODE_W-1:0]),
      .cmd        (cmd),
      .sts        (sts),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_num    (num),
      .out_new    (is_new),
      .out_lo     (lo),
      .out_hi     (hi),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   // Pack the result fields from the lowest bit up, zero filled to bytes.
   assign rsp_tdata = {3'b000, hi, lo, is_new, num};

endmodule

[tb/face_edge_dedup_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face edge dedup table testbench
// Streams mesh faces into the block one corner per transfer. A shadow edge
// table predicts every edge result, and the results are checked field by
// field. Both channels stall at random, including a long result hold-off.
// ----------------------------------------------------------------------------
module face_edge_dedup_table_tb;
   import fedt_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int FACE_DEPTH  = 8;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [19:0] node;
      logic        closes;
   } corner_type;

   typedef struct packed {
      logic [11:0]         edge_number;
      logic                is_new;
      logic [19:0]         low_node;
      logic [19:0]         high_node;
      logic [STATUS_W-1:0] status;
      logic                last_of_run;
   } edge_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // node[19:0], zero fill
   logic        req_tlast = 1'b0; // last_of_face
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // edge_number, is_new, low_node, high_node, fill
   logic [1:0]  rsp_tuser;        // status
   logic        rsp_tlast;        // last_of_run

   face_edge_dedup_table DUT (.*);

   always #6 clock = ~clock;

   // Shadow state of the block.
   logic [19:0] shadow_face[FACE_DEPTH];
   int          shadow_fill;
   bit          shadow_overlong;
   logic [19:0] shadow_lo[TABLE_DEPTH];
   logic [19:0] shadow_hi[TABLE_DEPTH];
   int          shadow_used;

   corner_type      pending_corners[$];
   edge_result_type expected_edges[$];
   int  mismatch_count = 0;
   int  result_count = 0;
   int  cycle_count = 0;
   bit  calm_phase = 1'b0;       // no idling in the last part of the run
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_off = 0;            // long receiver stall, counted in its own process
   bit  hold_request = 1'b0;
   bit  pause_request = 1'b0;

   task automatic push_edge(input logic [11:0] num, input logic fresh,
                            input logic [19:0] lo, input logic [19:0] hi,
                            input logic [1:0] st, input logic fin);
      edge_result_type r;
      r.edge_number = num; r.is_new = fresh; r.low_node = lo; r.high_node = hi;
      r.status = st; r.last_of_run = fin;
      expected_edges = {expected_edges, r};
   endtask

   // Predict the results caused by one accepted corner.
   task automatic predict_corner(input corner_type c);
      int n, j, e;
      logic [19:0] p, q, lo, hi;
      if (shadow_fill < FACE_DEPTH) begin
         shadow_face[shadow_fill] = c.node;
         shadow_fill++;
      end else begin
         shadow_overlong = 1'b1;
      end
      if (!c.closes) return;
      n = shadow_fill;
      if (shadow_overlong) begin
         push_edge('0, 1'b0, '0, '0, ST_LONG, 1'b1);
      end else if (n == 2) begin
         push_edge(shadow_face[0][11:0], 1'b0, shadow_face[0], shadow_face[0], ST_OK, 1'b0);
         push_edge(shadow_face[1][11:0], 1'b0, shadow_face[1], shadow_face[1], ST_OK, 1'b1);
      end else if (n >= 3) begin
         for (j = 0; j < n; j++) begin
            p = shadow_face[j];
            q = shadow_face[(j + 1 < n) ? j + 1 : 0];
            lo = (p < q) ? p : q;
            hi = (p < q) ? q : p;
            for (e = 0; e < shadow_used; e++)
               if (shadow_lo[e] == lo && shadow_hi[e] == hi) break;
            if (e < shadow_used) begin
               push_edge(e[11:0], 1'b0, lo, hi, ST_OK, j == n - 1);
            end else if (shadow_used < TABLE_DEPTH) begin
               shadow_lo[shadow_used] = lo;
               shadow_hi[shadow_used] = hi;
               push_edge(shadow_used[11:0], 1'b1, lo, hi, ST_OK, j == n - 1);
               shadow_used++;
            end else begin
               push_edge('0, 1'b0, lo, hi, ST_FULL, j == n - 1);
            end
         end
      end
      shadow_fill = 0;
      shadow_overlong = 1'b0;
   endtask

   // Driver: offers queued corners with random gaps, and none while a pause is asked.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_corner(pending_corners.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // Hold the current corner.
         end else if (pause_request || pending_corners.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 18);
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= {4'b0, pending_corners[0].node};
            req_tlast <= pending_corners[0].closes;
         end
      end
   end

   // Long receiver hold-off, started once on request.
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 0;
      end else if (hold_request && hold_off == 0) begin
         hold_off <= 400;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end
   end

   // Monitor: accepts results and compares them with the oldest prediction.
   always @(posedge clock) begin
      edge_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.edge_number = rsp_tdata[11:0];
            got.is_new      = rsp_tdata[12];
            got.low_node    = rsp_tdata[32:13];
            got.high_node   = rsp_tdata[52:33];
            got.status      = rsp_tuser;
            got.last_of_run = rsp_tlast;
            result_count <= result_count + 1;
            if (expected_edges.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected edge result %h", got);
            end else begin
               want = expected_edges.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display({"edge mismatch: num %0d/%0d new %b/%b lo %h/%h hi %h/%h",
                               " st %0d/%0d last %b/%b (exp/got)"},
                              want.edge_number, got.edge_number, want.is_new, got.is_new,
                              want.low_node, got.low_node, want.high_node, got.high_node,
                              want.status, got.status, want.last_of_run, got.last_of_run);
               end
            end
         end
         if (hold_request || hold_off > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic add_face(input int len, input int pool);
      corner_type c;
      for (int k = 0; k < len; k++) begin
         c.node = (pool == 0) ? 20'($urandom) : 20'($urandom_range(0, pool - 1));
         c.closes = (k == len - 1);
         pending_corners = {pending_corners, c};
      end
   endtask

   task automatic add_corner(input logic [19:0] node, input logic closes);
      corner_type c;
      c.node = node; c.closes = closes;
      pending_corners = {pending_corners, c};
   endtask

   task automatic wait_drained;
      while (pending_corners.size() != 0 || req_tvalid || expected_edges.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int len, total;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed faces: one-node, two-node, a triangle, the same triangle
      // reversed (all hits), a repeated node, extreme node values and an
      // overlong face.
      add_corner(20'h00005, 1'b1);
      add_corner(20'hFFFFF, 1'b0); add_corner(20'h00ABC, 1'b1);
      add_corner(20'h00001, 1'b0); add_corner(20'h00002, 1'b0);
      add_corner(20'h00003, 1'b1);
      add_corner(20'h00003, 1'b0); add_corner(20'h00002, 1'b0);
      add_corner(20'h00001, 1'b1);
      add_corner(20'h00000, 1'b0); add_corner(20'h00000, 1'b0);
      add_corner(20'hFFFFF, 1'b1);
      for (int k = 0; k < 10; k++) add_corner(20'h55555 ^ 20'(k), k == 9);
      wait_drained();

      // Random faces over a small node pool so that edges are shared; the
      // receiver holds off once for a long stretch while corners keep coming.
      total = 0;
      while (total < 300) begin
         case ($urandom_range(0, 19))
            0:       len = 1;
            1:       len = 2;
            2:       len = $urandom_range(9, 12);
            default: len = $urandom_range(3, 8);
         endcase
         add_face(len, ($urandom_range(0, 3) == 0) ? 0 : 48);
         total += len;
      end
      hold_request = 1'b1;
      wait (hold_off != 0);
      hold_request = 1'b0;

      // Sender pause until every expected result has come.
      while (pending_corners.size() > 150) @(posedge clock);
      pause_request = 1'b1;
      while (req_tvalid || expected_edges.size() != 0) @(posedge clock);
      pause_request = 1'b0;
      while (pending_corners.size() > 40) @(posedge clock);
      calm_phase = 1'b1;
      wait_drained();
      repeat (200) @(posedge clock);

      $display("covered %0d edge results, %0d table entries, short, long and overlong faces",
               result_count, shadow_used);
      $display("random stalls on both channels, a long result hold-off and a sender pause");
      if (mismatch_count == 0 && expected_edges.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
